### src/rmdw_pkg.sv
// Package: payload and config types, constants and the sine carrier table.
package rmdw_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
   localparam int SAMPLE_BITS      = 24;
   localparam int PHASE_BITS       = 24;
   localparam int STEP_BITS        = 23;
   localparam int MIX_BITS         = 17;
   localparam int CARRIER_BITS     = 25;
   localparam int GAIN_BITS        = 32;
   localparam int CSR_IDX_BITS     = 2;
   localparam int CSR_DATA_BITS    = 23;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PHASE_STEP    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIX_LEVEL     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEREO_ENABLE = 2'd2;

   localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = 23'd69905;
   localparam logic [MIX_BITS-1:0]  MIX_LEVEL_RESET  = 17'd32768;
   localparam logic [MIX_BITS-1:0]  MIX_UNITY        = 17'd65536;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic [STEP_BITS-1:0] phase_step;
      logic [MIX_BITS-1:0]  mix_level;
      logic                 stereo_enable;
   } cfg_type;

   typedef logic signed [CARRIER_BITS-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   // sin(2*pi*k/DEPTH), Q30 Taylor series through theta^15, unity = 2^23
   function automatic logic signed [CARRIER_BITS-1:0] sine_entry(input int unsigned k);
      logic [63:0]        a;
      logic [63:0]        r;
      logic [63:0]        theta;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic [1:0]         quad;
      logic signed [63:0] sum;
      a     = (64'(k) << 32) / SINE_TABLE_DEPTH;
      quad  = a[31:30];
      r     = {34'd0, a[29:0]};
      if (quad[0]) begin
         r = 64'h4000_0000 - r;
      end
      theta = (r * HALF_PI_Q30 + 64'h2000_0000) >> 30;
      term  = theta;
      sum   = signed'(theta);
      for (int n = 1; n <= 7; n++) begin
         term = (term * theta) >> 30;
         term = (term * theta) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      mag = (unsigned'(sum) + 64'd64) >> 7;
      return quad[1] ? -CARRIER_BITS'(mag) : CARRIER_BITS'(mag);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         rom[k] = sine_entry(k);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

### src/rmdw_carrier.sv
// Carrier NCO: phase accumulator, registered sine ROM read and gain computation.
module rmdw_carrier (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  rmdw_pkg::cfg_type                      cfg,
   output logic signed [rmdw_pkg::GAIN_BITS-1:0]  gain,
   output logic                                   gain_valid
);
   import rmdw_pkg::*;

   logic [PHASE_BITS-1:0]          phase_ff, phase_in;
   logic signed [CARRIER_BITS-1:0] carrier_ff;
   logic                           rom_valid_ff;
   logic [MIX_BITS-1:0]            mix_clamped;
   logic signed [CARRIER_BITS+MIX_BITS:0] cm_ff;
   logic [MIX_BITS-1:0]            dry_ff;
   logic                           cm_valid_ff;
   logic signed [43:0]             f_sum;
   logic signed [GAIN_BITS-1:0]    gain_ff;
   logic                           gain_valid_ff;

   assign phase_in    = phase_ff + PHASE_BITS'(cfg.phase_step);
   assign mix_clamped = (cfg.mix_level > MIX_UNITY) ? MIX_UNITY : cfg.mix_level;
   assign f_sum = signed'({4'd0, dry_ff, 23'd0}) + 44'(cm_ff) + 44'sd256;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         rom_valid_ff  <= 1'b0;
         cm_valid_ff   <= 1'b0;
         gain_valid_ff <= 1'b0;
      end else begin
         rom_valid_ff  <= start;
         cm_valid_ff   <= rom_valid_ff;
         gain_valid_ff <= cm_valid_ff;
         if (start) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         carrier_ff <= SINE_ROM[phase_ff[PHASE_BITS-1 -: SINE_IDX_BITS]];
      end
      if (rom_valid_ff) begin
         cm_ff  <= carrier_ff * signed'({1'b0, mix_clamped});
         dry_ff <= MIX_UNITY - mix_clamped;
      end
      if (cm_valid_ff) begin
         gain_ff <= f_sum[GAIN_BITS+8:9];
      end
   end

   assign gain       = gain_ff;
   assign gain_valid = gain_valid_ff;
endmodule

### src/rmdw_lane.sv
// One channel lane: sample times gain, then rounding and saturation.
module rmdw_lane (
   input  logic                                    clock,
   input  logic                                    load,
   input  logic signed [rmdw_pkg::SAMPLE_BITS-1:0] sample,
   input  logic signed [rmdw_pkg::GAIN_BITS-1:0]   gain,
   output logic signed [rmdw_pkg::SAMPLE_BITS-1:0] result
);
   import rmdw_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
   localparam int RND_BITS  = PROD_BITS - 30;

   localparam logic signed [RND_BITS-1:0] SAT_MAX = RND_BITS'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
   localparam logic signed [RND_BITS-1:0] SAT_MIN = RND_BITS'(-(64'sd1 <<< (SAMPLE_BITS-1)));

   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] rnd_sum;
   logic signed [RND_BITS-1:0]  rnd;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= sample * gain;
      end
   end

   assign rnd_sum = prod_ff + PROD_BITS'(64'sd1 <<< 29);
   assign rnd     = rnd_sum[PROD_BITS-1:30];

   always_comb begin
      if (rnd > SAT_MAX) begin
         result = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (rnd < SAT_MIN) begin
         result = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         result = rnd[SAMPLE_BITS-1:0];
      end
   end
endmodule

### src/ring_modulator_dry_wet.sv
// Top level: config registers, carrier, two channel lanes and the merging output stage.
//
//  channel | direction | handshake        | payload
//  req_    | in        | req_valid/stall  | req_data  (left_in, right_in)
//  rsp_    | out       | rsp_valid/stall  | rsp_data  (left_out, right_out)
//  csr_    | in        | csr_valid/ready  | csr_index, csr_wdata
//
// One item at a time: the result register loads after the ROM read at accept, the carrier*mix
// multiply, gain rounding, lane multiply and merge, each registered in that order; rsp_valid
// is set together with the result register, and no new item is taken until rsp is taken.
// req_stall is high while an item is in flight or its result waits in the output register.
// Reset (synchronous) zeroes the carrier phase and loads the register defaults.
module ring_modulator_dry_wet (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rmdw_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rmdw_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rmdw_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [rmdw_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import rmdw_pkg::*;

   cfg_type                     cfg_ff;
   req_type                     sample_ff;
   logic                        accept;
   logic                        busy_ff, busy_in;
   logic signed [GAIN_BITS-1:0] gain;
   logic                        gain_valid;
   logic                        lane_valid_ff;
   logic signed [SAMPLE_BITS-1:0] left_res, right_res;
   rsp_type                     rsp_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_done;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign rsp_done  = rsp_valid_ff && !rsp_stall;
   assign req_stall = busy_ff;
   assign busy_in   = accept ? 1'b1 : (rsp_done ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step    <= PHASE_STEP_RESET;
         cfg_ff.mix_level     <= MIX_LEVEL_RESET;
         cfg_ff.stereo_enable <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_STEP:    cfg_ff.phase_step    <= csr_wdata[STEP_BITS-1:0];
            CSR_MIX_LEVEL:     cfg_ff.mix_level     <= csr_wdata[MIX_BITS-1:0];
            CSR_STEREO_ENABLE: cfg_ff.stereo_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_data;
      end
   end

   rmdw_carrier u_carrier (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .cfg        (cfg_ff),
      .gain       (gain),
      .gain_valid (gain_valid)
   );

   rmdw_lane u_lane_left (
      .clock  (clock),
      .load   (gain_valid),
      .sample (sample_ff.left_in),
      .gain   (gain),
      .result (left_res)
   );

   rmdw_lane u_lane_right (
      .clock  (clock),
      .load   (gain_valid),
      .sample (sample_ff.right_in),
      .gain   (gain),
      .result (right_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         lane_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         lane_valid_ff <= gain_valid;
         if (lane_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_done) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // merge: mono mode zeroes the right lane
   always_ff @(posedge clock) begin
      if (lane_valid_ff) begin
         rsp_ff.left_out  <= left_res;
         rsp_ff.right_out <= cfg_ff.stereo_enable ? right_res : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

### src/rmdw_checker.sv
// Port-level checker for the top level, with its bind.
module rmdw_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input rmdw_pkg::rsp_type   rsp_data
);
   import rmdw_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req item taken while a result is pending");

   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("block not busy after accepting an item");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##5 rsp_valid)
      else $error("result not valid five cycles after accept");
endmodule

bind ring_modulator_dry_wet rmdw_checker u_rmdw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### dv/ring_modulator_dry_wet_test.sv
// Testbench for ring_modulator_dry_wet: directed table then randomized frames, scoreboard checked.
`timescale 1ns / 1ps

module ring_modulator_dry_wet_test;
   import rmdw_pkg::*;

   localparam int LIMIT_CYCLES  = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int RAND_PHASES   = 20;
   localparam int HOLD_PHASE    = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh80_0000;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_IDX_BITS-1:0]   idx;
      logic [CSR_DATA_BITS-1:0]  wdata;
      req_type                   frm;
      bit                        known;
      rsp_type                   want;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   logic signed [CARRIER_BITS-1:0] carrier_tab [SINE_TABLE_DEPTH];
   logic [PHASE_BITS-1:0]          nco_phase  = '0;
   logic [STEP_BITS-1:0]           step_cfg   = PHASE_STEP_RESET;
   logic [MIX_BITS-1:0]            mix_cfg    = MIX_LEVEL_RESET;
   logic                           stereo_cfg = 1'b1;

   rsp_type      expected_frames [$];
   stim_row_type stim_rows [$];
   int           mismatch_count = 0;
   bit           calm = 1'b0;
   bit           hold_request = 1'b0;

   ring_modulator_dry_wet uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // sin(2*pi*k/DEPTH): Q30 Taylor series through theta^15, unity = 2^23
   function automatic logic signed [CARRIER_BITS-1:0] carrier_point(input int unsigned k);
      logic [63:0]  turn;
      logic [63:0]  frac;
      logic [63:0]  ang;
      logic [63:0]  pw;
      logic [63:0]  mag;
      logic [1:0]   quadrant;
      longint       acc;
      turn     = (64'(k) << 32) / SINE_TABLE_DEPTH;
      quadrant = turn[31:30];
      frac     = {34'd0, turn[29:0]};
      if (quadrant[0]) begin
         frac = 64'h4000_0000 - frac;
      end
      ang = (frac * HALF_PI_Q30 + 64'h2000_0000) >> 30;
      pw  = ang;
      acc = longint'(ang);
      for (int n = 1; n <= 7; n++) begin
         pw = (pw * ang) >> 30;
         pw = (pw * ang) >> 30;
         pw = pw / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(pw);
         end else begin
            acc = acc + longint'(pw);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      mag = (64'(acc) + 64'd64) >> 7;
      return quadrant[1] ? -CARRIER_BITS'(mag) : CARRIER_BITS'(mag);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] mix_sample(
         input logic signed [SAMPLE_BITS-1:0] dry, input longint gain);
      longint rounded;
      rounded = (longint'(dry) * gain + (longint'(1) <<< 29)) >>> 30;
      if (rounded > longint'(SAMPLE_MAX)) begin
         rounded = longint'(SAMPLE_MAX);
      end
      if (rounded < longint'(SAMPLE_MIN)) begin
         rounded = longint'(SAMPLE_MIN);
      end
      return SAMPLE_BITS'(rounded);
   endfunction

   // carrier is read at the current phase, then the phase advances
   function automatic rsp_type ring_mod_frame(input req_type frm);
      rsp_type frame_out;
      longint  car;
      longint  mv;
      longint  wet;
      longint  gain;
      car       = carrier_tab[nco_phase[PHASE_BITS-1 -: SINE_IDX_BITS]];
      nco_phase = nco_phase + PHASE_BITS'(step_cfg);
      mv        = (mix_cfg > MIX_UNITY) ? longint'(MIX_UNITY) : longint'(mix_cfg);
      wet       = (longint'(MIX_UNITY) - mv) * (longint'(1) <<< 23) + car * mv;
      gain      = (wet + 256) >>> 9;
      frame_out.left_out  = mix_sample(frm.left_in, gain);
      frame_out.right_out = stereo_cfg ? mix_sample(frm.right_in, gain) : '0;
      return frame_out;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 80);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 19))
         0, 1: begin
            return SAMPLE_MAX;
         end
         2, 3: begin
            return SAMPLE_MIN;
         end
         4: begin
            return '0;
         end
         5: begin
            return 24'sd1;
         end
         6: begin
            return -24'sd1;
         end
         default: begin
            return SAMPLE_BITS'($urandom());
         end
      endcase
   endfunction

   function automatic void add_frame(input logic signed [SAMPLE_BITS-1:0] l, r,
         input bit known = 1'b0, input logic signed [SAMPLE_BITS-1:0] wl = '0, wr = '0);
      stim_row_type row;
      row.kind           = ROW_FRAME;
      row.idx            = '0;
      row.wdata          = '0;
      row.frm.left_in    = l;
      row.frm.right_in   = r;
      row.known          = known;
      row.want.left_out  = wl;
      row.want.right_out = wr;
      stim_rows          = {stim_rows, row};
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_BITS-1:0] idx,
         input logic [CSR_DATA_BITS-1:0] wdata);
      stim_row_type row;
      row.kind  = ROW_CSR;
      row.idx   = idx;
      row.wdata = wdata;
      row.frm   = '0;
      row.known = 1'b0;
      row.want  = '0;
      stim_rows = {stim_rows, row};
   endfunction

   task automatic report_mismatch(input string what, input logic [SAMPLE_BITS-1:0] got,
         input logic [SAMPLE_BITS-1:0] want);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("%0t mismatch on %s: got %0d, want %0d", $time, what,
                  $signed(got), $signed(want));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
         input logic [CSR_DATA_BITS-1:0] wdata);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PHASE_STEP: begin
            step_cfg = wdata[STEP_BITS-1:0];
         end
         CSR_MIX_LEVEL: begin
            mix_cfg = wdata[MIX_BITS-1:0];
         end
         CSR_STEREO_ENABLE: begin
            stereo_cfg = wdata[0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_frame(input req_type frm, input bit known, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= frm;
      do @(posedge clock); while (req_stall);
      predicted = ring_mod_frame(frm);
      if (known) begin
         predicted = want;
      end
      expected_frames = {expected_frames, predicted};
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int run;
      run       = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            rsp_stall    <= 1'b0;
            hold_request = 1'b0;
            run          = 0;
         end else if (run > 0) begin
            run--;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            run = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            report_mismatch("item with nothing due", rsp_data.left_out, '0);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_data.left_out !== want.left_out) begin
               report_mismatch("left_out", rsp_data.left_out, want.left_out);
            end
            if (rsp_data.right_out !== want.right_out) begin
               report_mismatch("right_out", rsp_data.right_out, want.right_out);
            end
         end
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("[ring_modulator_dry_wet] ERROR");
      $finish;
   end

   initial begin
      req_type                  frm;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0] wdata;
      int                       start;
      int                       count;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         carrier_tab[k] = carrier_point(k);
      end

      // reset defaults: carrier at zero, half wet
      add_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 24'sd4194304, -24'sd4194304);
      add_frame(24'sd1, -24'sd1);
      // two steps of this size land on the carrier trough
      add_csr(CSR_PHASE_STEP, 23'd6221551);
      add_frame(SAMPLE_MAX, SAMPLE_MAX);
      add_frame(-24'sd1, '0);
      add_csr(CSR_MIX_LEVEL, 23'd65536);
      add_frame(SAMPLE_MIN, SAMPLE_MAX);
      add_frame(SAMPLE_MIN, SAMPLE_MIN);
      // fully dry passes samples through
      add_csr(CSR_MIX_LEVEL, 23'd0);
      add_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1, SAMPLE_MAX, SAMPLE_MIN);
      add_frame(24'sd1, -24'sd1, 1'b1, 24'sd1, -24'sd1);
      add_csr(CSR_STEREO_ENABLE, 23'h7F_FFFE);
      add_frame(24'sh12_3456, SAMPLE_MAX, 1'b1, 24'sh12_3456, '0);
      // mix above unity saturates to fully wet
      add_csr(CSR_MIX_LEVEL, 23'h7F_FFFF);
      add_frame(SAMPLE_MAX, SAMPLE_MAX);
      add_csr(CSR_STEREO_ENABLE, 23'h7F_FFFF);
      add_csr(CSR_PHASE_STEP, 23'h7F_FFFF);
      add_frame(SAMPLE_MIN, SAMPLE_MAX);
      add_frame(24'sh55_5555, 24'shAA_AAAA);
      add_csr(CSR_PHASE_STEP, 23'd0);
      add_frame(SAMPLE_MAX, SAMPLE_MIN);
      add_frame(24'sh2A_AAAA, 24'shD5_5555);
      add_csr(CSR_SPARE, 23'h7F_FFFF);
      add_csr(CSR_MIX_LEVEL, 23'd1);
      add_frame(SAMPLE_MAX, SAMPLE_MIN);
      add_csr(CSR_MIX_LEVEL, 23'd65535);
      add_frame(SAMPLE_MIN, SAMPLE_MAX);
      add_csr(CSR_PHASE_STEP, 23'd1);
      add_frame('0, SAMPLE_MIN);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            write_csr(stim_rows[i].idx, stim_rows[i].wdata);
         end else begin
            send_frame(stim_rows[i].frm, stim_rows[i].known, stim_rows[i].want);
         end
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         start = $urandom_range(0, 3);
         for (int i = 0; i < 4; i++) begin
            idx = CSR_IDX_BITS'((start + i) % 4);
            case (idx)
               CSR_PHASE_STEP: begin
                  case ($urandom_range(0, 5))
                     0: wdata = '0;
                     1: wdata = '1;
                     2: wdata = 23'd1;
                     3: wdata = 23'($urandom_range(2, 4096));
                     default: wdata = 23'($urandom());
                  endcase
               end
               CSR_MIX_LEVEL: begin
                  wdata = 23'($urandom());
                  case ($urandom_range(0, 5))
                     0: wdata[MIX_BITS-1:0] = '0;
                     1: wdata[MIX_BITS-1:0] = MIX_UNITY;
                     2: wdata[MIX_BITS-1:0] = MIX_UNITY - 17'd1;
                     3: wdata[MIX_BITS-1:0] = 17'($urandom_range(65537, 131071));
                     default: wdata[MIX_BITS-1:0] = 17'($urandom_range(0, 65536));
                  endcase
               end
               default: begin
                  wdata = 23'($urandom());
               end
            endcase
            if (idx != CSR_SPARE || $urandom_range(0, 3) == 0) begin
               write_csr(idx, wdata);
            end
         end
         calm = ($urandom_range(0, 3) == 0);
         if (ph == HOLD_PHASE) begin
            calm         = 1'b1;
            hold_request = 1'b1;
         end
         count = $urandom_range(40, 85);
         repeat (count) begin
            frm.left_in  = pick_sample();
            frm.right_in = pick_sample();
            send_frame(frm, 1'b0, '0);
         end
      end

      calm = 1'b0;
      wait_idle();
      if (mismatch_count == 0) begin
         $display("[ring_modulator_dry_wet] OK");
      end else begin
         $display("[ring_modulator_dry_wet] ERROR");
      end
      $finish;
   end

endmodule
